// ===== rtl/core/swm_pkg.sv =====
package swm_pkg;

	// Field widths of one item
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned WIN_W      = 7;
	localparam int unsigned S_TDATA_W  = 40;
	localparam int unsigned M_TDATA_W  = 32;

	// One history entry held by a cell
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       vld;
	} entry_t;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic rot;   // rotate towards the head, the head wraps to the tail
		logic push;  // shift away from the head, new sample enters the head
		logic clr;   // drop every held sample (end of series)
	} cell_ctrl_t;

endpackage

// ===== rtl/core/swm_cell.sv =====
module swm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  swm_pkg::cell_ctrl_t ctrl,
	input  swm_pkg::entry_t     prev_entry,
	input  swm_pkg::entry_t     next_entry,
	output swm_pkg::entry_t     entry
);

	logic signed [swm_pkg::SAMPLE_W-1:0] smp_q;
	logic                                vld_q;

	// Hold valid flag; clear overrides any movement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clr) begin
			vld_q <= 1'b0;
		end else if (ctrl.push) begin
			vld_q <= prev_entry.vld;
		end else if (ctrl.rot) begin
			vld_q <= next_entry.vld;
		end
	end

	// Advance sample payload
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			smp_q <= prev_entry.smp;
		end else if (ctrl.rot) begin
			smp_q <= next_entry.smp;
		end
	end

	assign entry.smp = smp_q;
	assign entry.vld = vld_q;

endmodule

// ===== rtl/core/sliding_window_maximum_skip_invalid_core.sv =====
// Flow: an accepted item goes from idle to a scan of the history when a valid sample
// with a non-zero window has older samples to scan, otherwise straight to push.
// The block takes no new item until the last result is pushed; the scan is a
// full rotation of the cell chain past the head cell, one cell per cycle.
// Reset (arst_n low): history flags, sample count, running-maximum valid flag and
// output valid clear at once; no clearing pass is needed.
module sliding_window_maximum_skip_invalid_core #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] sample, [38:32] window, [39] zero
	input  logic [swm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// [0] sample_valid
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [31:0] max_value
	output logic [swm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// [0] result_valid
	output logic                              m_axis_tuser
);

	localparam int unsigned BW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PUSH} state_t;

	state_t                               state_q;
	logic signed [swm_pkg::SAMPLE_W-1:0]  smp_q;
	logic                                 vld_q;
	logic                                 last_q;
	logic [BW-1:0]                        back_q;
	logic [BW-1:0]                        j_q;
	logic signed [swm_pkg::SAMPLE_W-1:0]  acc_q;
	logic [CW-1:0]                        seen_q;
	logic signed [swm_pkg::SAMPLE_W-1:0]  series_max_q;
	logic                                 series_vld_q;
	logic                                 out_vld_q;
	logic [swm_pkg::M_TDATA_W-1:0]        out_max_q;
	logic                                 out_rv_q;

	logic signed [swm_pkg::SAMPLE_W-1:0]  in_smp;
	logic [swm_pkg::WIN_W-1:0]            in_win;
	logic                                 in_acc;
	logic                                 push_go;
	logic signed [swm_pkg::SAMPLE_W-1:0]  series_new;
	logic [CW-1:0]                        win_n;
	logic [CW-1:0]                        back_full;
	logic [BW-1:0]                        back_c;

	swm_pkg::cell_ctrl_t                  ctrl;
	swm_pkg::entry_t                      new_entry;
	swm_pkg::entry_t                      cells [DEPTH];
	logic [DEPTH-1:0]                     cell_vld;

	assign in_smp  = s_axis_tdata[swm_pkg::SAMPLE_W-1:0];
	assign in_win  = s_axis_tdata[swm_pkg::SAMPLE_W +: swm_pkg::WIN_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign push_go = (state_q == ST_PUSH) && (!out_vld_q || m_axis_tready);

	// Running maximum including the incoming sample
	always_comb begin
		series_new = series_max_q;
		if (!series_vld_q || in_smp > series_max_q) begin
			series_new = in_smp;
		end
	end

	// Look-back count: saturate window to DEPTH, clip to samples seen
	always_comb begin
		if (32'(in_win) >= DEPTH) begin
			win_n = CW'(DEPTH);
		end else begin
			win_n = CW'(in_win);
		end
		back_full = win_n - CW'(1);
		if (back_full > seen_q) begin
			back_c = BW'(seen_q);
		end else begin
			back_c = BW'(back_full);
		end
	end

	// Chain control
	always_comb begin
		ctrl.rot  = (state_q == ST_SCAN);
		ctrl.push = push_go;
		ctrl.clr  = push_go && last_q;
	end

	assign new_entry.smp = smp_q;
	assign new_entry.vld = vld_q;

	// Row of history cells; cell 0 holds the most recent sample
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		swm_pkg::entry_t prev_e;
		swm_pkg::entry_t next_e;
		if (i == 0) begin : g_head
			assign prev_e = new_entry;
		end else begin : g_body
			assign prev_e = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_e = cells[0];
		end else begin : g_inner
			assign next_e = cells[i+1];
		end
		swm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (cells[i])
		);
		assign cell_vld[i] = cells[i].vld;
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			j_q          <= '0;
			seen_q       <= '0;
			series_vld_q <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && !push_go) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						j_q <= '0;
						if (s_axis_tuser) begin
							series_vld_q <= 1'b1;
						end
						if (s_axis_tuser && in_win != '0 && back_c != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_SCAN: begin
					j_q <= j_q + BW'(1);
					if (j_q == BW'(DEPTH - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_go) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
						if (last_q) begin
							seen_q       <= '0;
							series_vld_q <= 1'b0;
						end else if (seen_q < CW'(DEPTH)) begin
							seen_q <= seen_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture item, fold the scanned cells into the window maximum
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= in_smp;
			vld_q  <= s_axis_tuser;
			last_q <= s_axis_tlast;
			back_q <= back_c;
			if (!s_axis_tuser) begin
				acc_q <= '0;
			end else if (in_win == '0) begin
				acc_q <= series_new;
			end else begin
				acc_q <= in_smp;
			end
			if (s_axis_tuser) begin
				series_max_q <= series_new;
			end
		end
		if (state_q == ST_SCAN && j_q < back_q && cells[0].vld && cells[0].smp > acc_q) begin
			acc_q <= cells[0].smp;
		end
		if (push_go) begin
			out_max_q <= acc_q;
			out_rv_q  <= vld_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_max_q;
	assign m_axis_tuser  = out_rv_q;

	// An invalid sample gives a zero maximum
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid result carries non-zero value");

	// A scan always starts from the head of the chain
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && $past(state_q) == ST_IDLE |-> j_q == '0)
		else $error("scan started with non-zero step count");

	// Sample count never exceeds the history depth
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CW'(DEPTH))
		else $error("sample count above depth");

	// End of series leaves no sample in the history
	a_series_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push_go && last_q |=> cell_vld == '0 && seen_q == '0 && !series_vld_q)
		else $error("history not cleared after last item");

	// A result is only written into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push_go |-> !m_axis_tvalid || m_axis_tready)
		else $error("output overwritten while stalled");

endmodule
